// ===== sv/lsd_rs_pkg.sv =====
// ----------------------------------------------------------------------------
// lsd_rs_pkg
// Shared widths, microcode format and control program of the radix sorter.
// ----------------------------------------------------------------------------
package lsd_rs_pkg;

   localparam int VAL_W      = 31;
   localparam int TDATA_W    = ((VAL_W + 7) / 8) * 8;
   localparam int MAX_ITEMS  = 64;
   localparam int DIGIT_BASE = 10;
   localparam int ADDR_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
   localparam int DIGIT_W    = $clog2(DIGIT_BASE);
   localparam int WORD_W     = 2 * VAL_W;
   localparam int DIV_STEPS  = 2;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
   localparam int STEP_W     = 5;

   // scaled reciprocal of the digit base, exact for every VAL_W-bit dividend
   localparam int RECIP_SHIFT = VAL_W + DIGIT_W;
   localparam int RECIP_W     = VAL_W + 1;
   localparam int PROD_W      = VAL_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_MUL =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIGIT_BASE) - 64'd1) / 64'(DIGIT_BASE));

   // jump conditions of a control word
   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NOT_ACC_LAST,
      COND_MAX_ZERO,
      COND_DIV_BUSY,
      COND_NOT_IDX_LAST,
      COND_NOT_IDX_ZERO,
      COND_NOT_J_LAST,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      logic load_en;
      logic cnt_clear;
      logic idx_zero;
      logic rd_en;
      logic div_item;
      logic div_max;
      logic count_inc;
      logic idx_inc;
      logic pfx;
      logic idx_top;
      logic place_wr;
      logic idx_dec;
      logic sel_toggle;
      logic max_load;
      logic out_load;
      logic set_clear;
   } ctl_type;

   typedef struct packed {
      logic acc_last;
      logic max_zero;
      logic div_busy;
      logic idx_last;
      logic idx_zero;
      logic j_last;
      logic out_busy;
   } stat_type;

   typedef struct packed {
      cond_type            cond;
      logic [STEP_W-1:0]   target;
      ctl_type             ctl;
   } ucode_type;

   // program addresses
   localparam logic [STEP_W-1:0] S_LOAD     = 5'd0;
   localparam logic [STEP_W-1:0] S_PASS     = 5'd1;
   localparam logic [STEP_W-1:0] S_CNT_RD   = 5'd2;
   localparam logic [STEP_W-1:0] S_CNT_DIV  = 5'd3;
   localparam logic [STEP_W-1:0] S_CNT_WAIT = 5'd4;
   localparam logic [STEP_W-1:0] S_CNT_ADD  = 5'd5;
   localparam logic [STEP_W-1:0] S_PFX      = 5'd6;
   localparam logic [STEP_W-1:0] S_PL_RD    = 5'd7;
   localparam logic [STEP_W-1:0] S_PL_DIV   = 5'd8;
   localparam logic [STEP_W-1:0] S_PL_WAIT  = 5'd9;
   localparam logic [STEP_W-1:0] S_PL_WR    = 5'd10;
   localparam logic [STEP_W-1:0] S_MX_DIV   = 5'd11;
   localparam logic [STEP_W-1:0] S_MX_WAIT  = 5'd12;
   localparam logic [STEP_W-1:0] S_MX_UPD   = 5'd13;
   localparam logic [STEP_W-1:0] S_EM_RD    = 5'd14;
   localparam logic [STEP_W-1:0] S_EM_OUT   = 5'd15;
   localparam logic [STEP_W-1:0] S_EM_NEXT  = 5'd16;
   localparam logic [STEP_W-1:0] S_DONE     = 5'd17;

   function automatic ucode_type lsd_rs_ucode(input logic [STEP_W-1:0] step);
      ucode_type w;
      w        = '0;
      w.cond   = COND_NEVER;
      w.target = S_LOAD;
      case (step)
         S_LOAD: begin
            w.ctl.load_en = 1'b1;
            w.cond = COND_NOT_ACC_LAST;  w.target = S_LOAD;
         end
         S_PASS: begin
            w.ctl.cnt_clear = 1'b1;
            w.ctl.idx_zero  = 1'b1;
            w.cond = COND_MAX_ZERO;  w.target = S_EM_RD;
         end
         S_CNT_RD:   w.ctl.rd_en = 1'b1;
         S_CNT_DIV:  w.ctl.div_item = 1'b1;
         S_CNT_WAIT: begin
            w.cond = COND_DIV_BUSY;  w.target = S_CNT_WAIT;
         end
         S_CNT_ADD: begin
            w.ctl.count_inc = 1'b1;
            w.ctl.idx_inc   = 1'b1;
            w.cond = COND_NOT_IDX_LAST;  w.target = S_CNT_RD;
         end
         S_PFX: begin
            w.ctl.pfx     = 1'b1;
            w.ctl.idx_top = 1'b1;
            w.cond = COND_NOT_J_LAST;  w.target = S_PFX;
         end
         S_PL_RD:   w.ctl.rd_en = 1'b1;
         S_PL_DIV:  w.ctl.div_item = 1'b1;
         S_PL_WAIT: begin
            w.cond = COND_DIV_BUSY;  w.target = S_PL_WAIT;
         end
         S_PL_WR: begin
            w.ctl.place_wr = 1'b1;
            w.ctl.idx_dec  = 1'b1;
            w.cond = COND_NOT_IDX_ZERO;  w.target = S_PL_RD;
         end
         S_MX_DIV: begin
            w.ctl.div_max    = 1'b1;
            w.ctl.sel_toggle = 1'b1;
         end
         S_MX_WAIT: begin
            w.cond = COND_DIV_BUSY;  w.target = S_MX_WAIT;
         end
         S_MX_UPD: begin
            w.ctl.max_load = 1'b1;
            w.cond = COND_ALWAYS;  w.target = S_PASS;
         end
         S_EM_RD:  w.ctl.rd_en = 1'b1;
         S_EM_OUT: begin
            w.ctl.out_load = 1'b1;
            w.cond = COND_OUT_BUSY;  w.target = S_EM_OUT;
         end
         S_EM_NEXT: begin
            w.ctl.idx_inc = 1'b1;
            w.cond = COND_NOT_IDX_LAST;  w.target = S_EM_RD;
         end
         S_DONE: begin
            w.ctl.set_clear = 1'b1;
            w.cond = COND_ALWAYS;  w.target = S_LOAD;
         end
         default: begin
            w.cond = COND_ALWAYS;  w.target = S_LOAD;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== sv/lsd_radix_sort.sv =====
// ----------------------------------------------------------------------------
// lsd_radix_sort
// Base-10 least-significant-digit radix sorter for up to 64 values.
// ----------------------------------------------------------------------------
// Values stream in on the req_ channel, one transaction per cycle while the
// block is loading. A transaction with req_tlast set closes the set and
// starts the sort; req_tready then stays low until the last result of the
// set has been placed in the output register.
// Values past the 64th are dropped and rsp_tuser is then set on every
// result of that set. Results leave on the rsp_ channel in ascending order,
// rsp_tlast on the last one, one result per stored value.
// Sorting makes one counting pass per decimal digit of the maximum; each
// item visit waits on the digit unit (reciprocal multiply, then remainder).
// Emission ends with a return to loading; a stalled receiver holds the
// output register and the sequencer.
// Synchronous reset empties the set and drops any pending result; the
// value stores keep stale contents, which are never read.
// ----------------------------------------------------------------------------
module lsd_radix_sort (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lsd_rs_pkg::TDATA_W-1:0]   req_tdata,  // [30:0] value
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lsd_rs_pkg::TDATA_W-1:0]   rsp_tdata,  // [30:0] sorted_value
   output logic                             rsp_tlast,
   output logic                             rsp_tuser   // [0] overflow
);
   import lsd_rs_pkg::*;

   ctl_type  ctl;
   stat_type stat;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [VAL_W-1:0]   max_ff, max_in;
   logic               dropped_ff, dropped_in;
   logic               sel_ff, sel_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [DIGIT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0]   counts_ff [DIGIT_BASE];
   logic [CNT_W-1:0]   counts_in [DIGIT_BASE];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]   rsp_value_ff, rsp_value_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic               accept, load_wr, out_busy, out_load, div_busy, div_start;
   logic [VAL_W-1:0]   div_quo, div_arg, in_value;
   logic [DIGIT_W-1:0] div_rem;
   logic [CNT_W-1:0]   place_pos, idx_top;
   logic [WORD_W-1:0]  rd0, rd1, rd_word, load_word, place_word;
   logic               we0, we1;
   logic [ADDR_W-1:0]  wa0, rd_addr;

   lsd_rs_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   lsd_rs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_arg),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // two stores in ping-pong: sel_ff names the one holding the current order
   lsd_rs_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ITEMS)) u_ram0 (
      .clock   (clock),
      .wr_en   (we0),
      .wr_addr (wa0),
      .wr_data (load_wr ? load_word : place_word),
      .rd_en   (ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd0)
   );

   lsd_rs_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ITEMS)) u_ram1 (
      .clock   (clock),
      .wr_en   (we1),
      .wr_addr (place_pos[ADDR_W-1:0]),
      .wr_data (place_word),
      .rd_en   (ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd1)
   );

   assign req_tready = ctl.load_en;
   assign accept     = req_tvalid && req_tready;
   assign in_value   = req_tdata[VAL_W-1:0];
   assign load_wr    = accept && (count_ff < CNT_W'(MAX_ITEMS));

   // stored word: remaining quotient in the upper half, original value below
   assign load_word  = {in_value, in_value};
   assign rd_word    = sel_ff ? rd1 : rd0;
   assign place_word = {div_quo, rd_word[VAL_W-1:0]};
   assign place_pos  = counts_ff[div_rem] - CNT_W'(1);
   assign idx_top    = count_ff - CNT_W'(1);
   assign rd_addr    = idx_ff[ADDR_W-1:0];

   assign we0 = load_wr || (ctl.place_wr && sel_ff);
   assign we1 = ctl.place_wr && !sel_ff;
   assign wa0 = load_wr ? count_ff[ADDR_W-1:0] : place_pos[ADDR_W-1:0];

   assign div_start = ctl.div_item || ctl.div_max;
   assign div_arg   = ctl.div_max ? max_ff : rd_word[WORD_W-1:VAL_W];

   assign out_busy = rsp_valid_ff && !rsp_tready;
   assign out_load = ctl.out_load && !out_busy;

   always_comb begin
      stat.acc_last = accept && req_tlast;
      stat.max_zero = (max_ff == '0);
      stat.div_busy = div_busy;
      stat.idx_last = (idx_ff == idx_top);
      stat.idx_zero = (idx_ff == '0);
      stat.j_last   = (j_ff == DIGIT_W'(DIGIT_BASE - 1));
      stat.out_busy = out_busy;
   end

   always_comb begin
      count_in     = count_ff;
      max_in       = max_ff;
      dropped_in   = dropped_ff;
      sel_in       = sel_ff;
      idx_in       = idx_ff;
      j_in         = j_ff;
      counts_in    = counts_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (load_wr) begin
         count_in = count_ff + CNT_W'(1);
         if (in_value > max_ff) begin
            max_in = in_value;
         end
      end else if (accept) begin
         dropped_in = 1'b1;
      end

      if (ctl.cnt_clear) begin
         for (int k = 0; k < DIGIT_BASE; k++) begin
            counts_in[k] = '0;
         end
         j_in = DIGIT_W'(1);
      end
      if (ctl.idx_zero) idx_in = '0;
      if (ctl.count_inc) counts_in[div_rem] = counts_ff[div_rem] + CNT_W'(1);
      if (ctl.idx_inc) idx_in = idx_ff + CNT_W'(1);
      if (ctl.pfx) begin
         counts_in[j_ff] = counts_ff[j_ff] + counts_ff[j_ff - DIGIT_W'(1)];
         j_in = j_ff + DIGIT_W'(1);
      end
      if (ctl.idx_top) idx_in = idx_top;
      if (ctl.place_wr) counts_in[div_rem] = place_pos;
      if (ctl.idx_dec) idx_in = idx_ff - CNT_W'(1);
      if (ctl.sel_toggle) sel_in = !sel_ff;
      if (ctl.max_load) max_in = div_quo;

      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = rd_word[VAL_W-1:0];
         rsp_last_in  = (idx_ff == idx_top);
         rsp_ovf_in   = dropped_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (ctl.set_clear) begin
         count_in   = '0;
         max_in     = '0;
         dropped_in = 1'b0;
         sel_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         max_ff       <= '0;
         dropped_ff   <= 1'b0;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         max_ff       <= max_in;
         dropped_ff   <= dropped_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      j_ff         <= j_in;
      counts_ff    <= counts_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_value_ff);
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ovf_ff;

   // closing a set stops the input side at once
   a_last_stops_input: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("input still ready after the closing transaction");

   // the divider never runs while values are being loaded
   a_no_div_in_load: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_busy)
      else $error("divider busy during load");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ITEMS))
      else $error("item count beyond capacity");

   // a placement lands inside the filled part of the store
   a_place_in_range: assert property (@(posedge clock) disable iff (reset)
      ctl.place_wr |-> (counts_ff[div_rem] != '0) && (place_pos < count_ff))
      else $error("placement address out of range");

endmodule

// ===== sv/lsd_rs_ram.sv =====
// ----------------------------------------------------------------------------
// lsd_rs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lsd_rs_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/lsd_rs_div.sv =====
// ----------------------------------------------------------------------------
// lsd_rs_div
// Divider by the digit base through a scaled reciprocal.
// ----------------------------------------------------------------------------
module lsd_rs_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [lsd_rs_pkg::VAL_W-1:0]   dividend,
   output logic                           busy,
   output logic [lsd_rs_pkg::VAL_W-1:0]   quotient,
   output logic [lsd_rs_pkg::DIGIT_W-1:0] remainder
);
   import lsd_rs_pkg::*;

   logic [VAL_W-1:0]     arg_ff, arg_in;
   logic [VAL_W-1:0]     quo_ff, quo_in;
   logic [DIGIT_W-1:0]   rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [PROD_W-1:0]    prod;
   logic [DIGIT_W-1:0]   q_low;

   // forms the quotient first, then the digit from the low bits
   always_comb begin
      prod  = PROD_W'(arg_ff) * PROD_W'(RECIP_MUL);
      q_low = quo_ff[DIGIT_W-1:0];

      arg_in = arg_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (start) begin
         arg_in = dividend;
         cnt_in = DIV_CNT_W'(DIV_STEPS);
      end else if (cnt_ff == DIV_CNT_W'(DIV_STEPS)) begin
         quo_in = VAL_W'(prod[PROD_W-1:RECIP_SHIFT]);
         cnt_in = cnt_ff - DIV_CNT_W'(1);
      end else if (cnt_ff != '0) begin
         rem_in = arg_ff[DIGIT_W-1:0] - DIGIT_W'(q_low * DIGIT_W'(DIGIT_BASE));
         cnt_in = cnt_ff - DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      arg_ff <= arg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy      = (cnt_ff != '0);
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== sv/lsd_rs_seq.sv =====
// ----------------------------------------------------------------------------
// lsd_rs_seq
// Step counter and control store; issues one control word per cycle.
// ----------------------------------------------------------------------------
module lsd_rs_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  lsd_rs_pkg::stat_type  stat,
   output lsd_rs_pkg::ctl_type   ctl
);
   import lsd_rs_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   ucode_type         word;
   logic              take;

   assign word = lsd_rs_ucode(step_ff);

   always_comb begin
      case (word.cond)
         COND_NEVER:        take = 1'b0;
         COND_ALWAYS:       take = 1'b1;
         COND_NOT_ACC_LAST: take = !stat.acc_last;
         COND_MAX_ZERO:     take = stat.max_zero;
         COND_DIV_BUSY:     take = stat.div_busy;
         COND_NOT_IDX_LAST: take = !stat.idx_last;
         COND_NOT_IDX_ZERO: take = !stat.idx_zero;
         COND_NOT_J_LAST:   take = !stat.j_last;
         COND_OUT_BUSY:     take = stat.out_busy;
         default:           take = 1'b1;
      endcase
      step_in = take ? word.target : step_ff + STEP_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_LOAD;
      end else begin
         step_ff <= step_in;
      end
   end

   assign ctl = word.ctl;

endmodule

// ===== tb/lsd_radix_sort_test.sv =====
// ----------------------------------------------------------------------------
// lsd_radix_sort_test
// Self-checking testbench for the base-10 radix sorter.
// ----------------------------------------------------------------------------
// Sends sets of values on the req_ stream and closes each set with tlast.
// A scoreboard keeps its own copy of the loaded set and runs a base-10 LSD
// counting sort when the closing transaction is accepted. Every rsp_
// transaction is then compared field by field with the oldest sorted value
// still waiting. The run starts with a short directed list: zeros only,
// extreme values and duplicates. Next comes a set that overruns the store
// and is closed by a dropped value. Random sets with mixed value ranges
// follow. Both sides stall at random, with one stretch that never stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsd_radix_sort_test;

   localparam int VAL_W     = lsd_rs_pkg::VAL_W;
   localparam int TDATA_W   = lsd_rs_pkg::TDATA_W;
   localparam int MAX_ITEMS = lsd_rs_pkg::MAX_ITEMS;
   localparam int BASE      = lsd_rs_pkg::DIGIT_BASE;

   localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

   typedef enum int {
      MIX_DIGIT,
      MIX_SMALL,
      MIX_WIDTH,
      MIX_FULL,
      MIX_REPEAT
   } value_mix_type;

   typedef struct {
      logic [VAL_W-1:0] value;
      logic             last;
      logic             overflow;
   } sorted_word_type;

   class sort_scoreboard_type;
      logic [VAL_W-1:0] set_values[$];
      logic [VAL_W-1:0] set_max;
      bit               set_dropped;
      sorted_word_type  sorted_expect[$];
      int               mismatches;
      int               results_checked;
      int               overflow_sets;

      function new();
         set_max         = '0;
         set_dropped     = 1'b0;
         mismatches      = 0;
         results_checked = 0;
         overflow_sets   = 0;
      endfunction

      function int pending();
         return sorted_expect.size();
      endfunction

      // one stable counting pass per decimal digit of the set maximum
      function void sort_set();
         logic [VAL_W-1:0] placed[MAX_ITEMS];
         int unsigned      counts[BASE];
         longint unsigned  place;
         int               n;
         int               d;
         n     = set_values.size();
         place = 1;
         while ((longint'(set_max) / place) > 0) begin
            foreach (counts[k]) counts[k] = 0;
            for (int i = 0; i < n; i++) begin
               d = int'((longint'(set_values[i]) / place) % BASE);
               counts[d]++;
            end
            for (int k = 1; k < BASE; k++) counts[k] += counts[k-1];
            for (int i = n - 1; i >= 0; i--) begin
               d = int'((longint'(set_values[i]) / place) % BASE);
               counts[d]--;
               placed[counts[d]] = set_values[i];
            end
            for (int i = 0; i < n; i++) set_values[i] = placed[i];
            place = place * BASE;
         end
      endfunction

      function void note_value(logic [VAL_W-1:0] value, logic last);
         sorted_word_type word;
         if (set_values.size() < MAX_ITEMS) begin
            set_values = {set_values, value};
            if (value > set_max) set_max = value;
         end else begin
            set_dropped = 1'b1;
         end
         if (last) begin
            sort_set();
            if (set_dropped) overflow_sets++;
            foreach (set_values[i]) begin
               word.value    = set_values[i];
               word.last     = (i == set_values.size() - 1);
               word.overflow = set_dropped;
               sorted_expect = {sorted_expect, word};
            end
            set_values.delete();
            set_max     = '0;
            set_dropped = 1'b0;
         end
      endfunction

      task report(string what);
         $display("[%0t] mismatch: %s", $realtime, what);
         mismatches++;
      endtask

      task check_result(logic [VAL_W-1:0] value, logic last, logic overflow);
         sorted_word_type want;
         results_checked++;
         if (sorted_expect.size() == 0) begin
            report($sformatf("unexpected result value %0d", value));
         end else begin
            want = sorted_expect.pop_front();
            if (value !== want.value)
               report($sformatf("sorted_value %0d, expected %0d", value, want.value));
            if (last !== want.last)
               report($sformatf("last_out %b, expected %b on value %0d",
                                last, want.last, want.value));
            if (overflow !== want.overflow)
               report($sformatf("overflow %b, expected %b on value %0d",
                                overflow, want.overflow, want.value));
         end
      endtask
   endclass

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [TDATA_W-1:0] req_tdata  = '0;     // [30:0] value
   logic               req_tlast  = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [TDATA_W-1:0] rsp_tdata;           // [30:0] sorted_value
   logic               rsp_tlast;
   logic               rsp_tuser;           // [0] overflow

   sort_scoreboard_type board;
   bit                  steady     = 1'b0;
   int                  items_sent = 0;
   int                  sets_sent  = 0;

   lsd_radix_sort dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial board = new();

   // result side: check each accepted transaction and pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata[VAL_W-1:0], rsp_tlast, rsp_tuser);
      rsp_tready <= steady || ($urandom_range(99) >= 36);
   end

   task automatic send_item(input logic [VAL_W-1:0] value, input logic last);
      while (!steady && $urandom_range(99) < 36) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= TDATA_W'(value);
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      board.note_value(value, last);
      items_sent++;
   endtask

   function automatic logic [VAL_W-1:0] pick_value(value_mix_type mix);
      logic [31:0] mask;
      int          w;
      if ($urandom_range(19) == 0)
         return ($urandom_range(1) == 1) ? VAL_MAX : '0;
      case (mix)
         MIX_DIGIT:  return VAL_W'($urandom_range(0, 9));
         MIX_SMALL:  return VAL_W'($urandom_range(0, 999));
         MIX_WIDTH: begin
            w    = $urandom_range(1, VAL_W);
            mask = (32'h1 << w) - 32'h1;
            return VAL_W'($urandom & mask);
         end
         MIX_REPEAT: return VAL_W'($urandom_range(0, 3) * 111111);
         default:    return VAL_W'($urandom);
      endcase
   endfunction

   task automatic send_set(input int size, input value_mix_type mix);
      for (int i = 0; i < size; i++)
         send_item(pick_value(mix), i == size - 1);
      sets_sent++;
   endtask

   task automatic send_list(input logic [VAL_W-1:0] values[$]);
      foreach (values[i]) send_item(values[i], i == values.size() - 1);
      sets_sent++;
   endtask

   initial begin
      int size;
      int r;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed sets
      send_list('{31'd0});
      send_list('{31'd0, 31'd0, 31'd0});
      send_list('{VAL_MAX});
      send_list('{VAL_MAX, 31'd0, 31'd1, 31'h4000_0000, 31'h5555_5555,
                  31'h2AAA_AAAA, 31'd10, 31'd9});
      send_list('{31'd5, 31'd5, 31'd5, 31'd3});
      send_list('{31'd100, 31'd7, 31'd1000000000, 31'd42});

      // hold the stream until every sorted value has come back
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);

      // overrun the store; the closing transaction itself is dropped
      send_set(MAX_ITEMS + 2, MIX_WIDTH);

      while (items_sent < 460) begin
         steady <= (sets_sent >= 12 && sets_sent < 18);
         r = $urandom_range(99);
         if (r < 60)      size = $urandom_range(1, 8);
         else if (r < 85) size = $urandom_range(9, 24);
         else if (r < 95) size = $urandom_range(25, MAX_ITEMS);
         else             size = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8);
         send_set(size, value_mix_type'($urandom_range(0, 4)));
      end
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (64) @(posedge clock);

      $display("sent %0d values in %0d sets, %0d of them overrunning the store",
               items_sent, sets_sent, board.overflow_sets);
      $display("checked %0d sorted results, %0d mismatches",
               board.results_checked, board.mismatches);
      if (board.mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #36_000_000;
      $display("timeout with %0d sorted values outstanding", board.pending());
      $display("FAIL");
      $finish;
   end

endmodule
